// ----- hdl/arp_pkg.sv -----
`timescale 1ns / 1ps
package arp_pkg;

   localparam int CACHE_ENTRIES_DEF   = 16;
   localparam int REQUEST_ENTRIES_DEF = 8;
   localparam int PENDING_ENTRIES_DEF = 16;

   localparam logic [15:0] LIFETIME_RESET = 16'd30000;
   localparam logic [15:0] HOLDOFF_RESET  = 16'd5000;

   localparam logic [15:0] ETH_IPV4  = 16'h0800;
   localparam logic [15:0] ETH_ARP   = 16'h0806;
   localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
   localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

   localparam logic [1:0] OP_SEND = 2'd0;
   localparam logic [1:0] OP_RECV = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   // Register index, taken from paddr[4:3].
   localparam logic [1:0] REG_OWN_MAC  = 2'd0;
   localparam logic [1:0] REG_OWN_IP   = 2'd1;
   localparam logic [1:0] REG_LIFETIME = 2'd2;
   localparam logic [1:0] REG_HOLDOFF  = 2'd3;

   localparam logic [2:0] RK_FRAME   = 3'd0;
   localparam logic [2:0] RK_REQUEST = 3'd1;
   localparam logic [2:0] RK_REPLY   = 3'd2;
   localparam logic [2:0] RK_DELIVER = 3'd3;
   localparam logic [2:0] RK_DROP    = 3'd4;

   localparam int CMD_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] next_hop_ip;
      logic [15:0] datagram_handle;
      logic [47:0] frame_dst_mac;
      logic [15:0] frame_ethertype;
      logic        payload_ok;
      logic [15:0] arp_opcode;
      logic [47:0] arp_sender_mac;
      logic [31:0] arp_sender_ip;
      logic [31:0] arp_target_ip;
      logic [15:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [47:0] dest_mac;
      logic [15:0] out_handle;
      logic [31:0] request_target_ip;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_SEND,
      CMD_DELIVER,
      CMD_ARP,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  ip;
      logic [47:0]  mac;
      logic [15:0]  handle;
      logic [15:0]  elapsed;
      logic         reply;
   } cmd_type;

endpackage

// ----- hdl/arp_resolver_with_pending_queue.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  arp_pkg::req_type
// rsp      out        rsp_valid / rsp_stall  arp_pkg::rsp_type
// csr      in/out     psel/penable/pready    64-bit registers at 8*index
//
// A send walks the cache table and, on a miss, the request table; an ARP frame walks the
// cache table and then the pending queue, and sends a reply if it asks for one; a tick
// walks the cache and request tables together and then the pending queue. The walks
// visit one entry per cycle, except while a result waits for room on rsp.
// Reset is synchronous and clears valid bits, request timers, the pending count and the queue.
// A stall on rsp holds the back end in place; the front keeps taking transactions
// until its two-entry command queue is full.
module arp_resolver_with_pending_queue #(
   parameter int CACHE_ENTRIES   = arp_pkg::CACHE_ENTRIES_DEF,
   parameter int REQUEST_ENTRIES = arp_pkg::REQUEST_ENTRIES_DEF,
   parameter int PENDING_ENTRIES = arp_pkg::PENDING_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  arp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output arp_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [63:0]      pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);
   import arp_pkg::*;

   localparam int PC_W = $clog2(PENDING_ENTRIES + 1);

   // Configuration registers; the user must write them only while the block is idle (not enforced here).
   logic [47:0] own_mac_ff;
   logic [31:0] own_ip_ff;
   logic [15:0] lifetime_ff;
   logic [15:0] holdoff_ff;
   logic [1:0]  reg_idx;

   logic            cmd_valid;
   cmd_type         cmd;
   logic            cmd_pop;
   logic [PC_W-1:0] pend_count;

   assign reg_idx = paddr[4:3];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff  <= '0;
         own_ip_ff   <= '0;
         lifetime_ff <= LIFETIME_RESET;
         holdoff_ff  <= HOLDOFF_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_OWN_MAC:  own_mac_ff  <= pwdata[47:0];
            REG_OWN_IP:   own_ip_ff   <= pwdata[31:0];
            REG_LIFETIME: lifetime_ff <= pwdata[15:0];
            REG_HOLDOFF:  holdoff_ff  <= pwdata[15:0];
            default:      own_ip_ff   <= own_ip_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_OWN_MAC:  prdata = {16'd0, own_mac_ff};
         REG_OWN_IP:   prdata = {32'd0, own_ip_ff};
         REG_LIFETIME: prdata = {48'd0, lifetime_ff};
         REG_HOLDOFF:  prdata = {48'd0, holdoff_ff};
         default:      prdata = '0;
      endcase
   end

   // The front filters and classifies each transaction into a command.
   arp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .own_mac   (own_mac_ff),
      .own_ip    (own_ip_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // The back walks the cache, request and pending tables for one command at a time.
   arp_back #(
      .CACHE_ENTRIES   (CACHE_ENTRIES),
      .REQUEST_ENTRIES (REQUEST_ENTRIES),
      .PENDING_ENTRIES (PENDING_ENTRIES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cache_lifetime_ms  (lifetime_ff),
      .request_holdoff_ms (holdoff_ff),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data           (rsp_data),
      .pend_count         (pend_count)
   );

   // The pending queue never holds more than its capacity.
   assert property (@(posedge clock) disable iff (reset)
      pend_count <= PC_W'(PENDING_ENTRIES))
      else $error("pending count exceeds capacity");

   // No result is presented in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Only defined result kinds leave the block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.result_kind <= RK_DROP)
      else $error("undefined result kind");

   // The command queue is only popped when it holds a command.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

endmodule

// ----- hdl/arp_front.sv -----
`timescale 1ns / 1ps
module arp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic [47:0]      own_mac,
   input  logic [31:0]      own_ip,
   input  logic             req_valid,
   output logic             req_stall,
   input  arp_pkg::req_type req_data,
   output logic             cmd_valid,
   output arp_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   import arp_pkg::*;

   localparam int QW = $clog2(CMD_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_type            q_ff [CMD_QUEUE_DEPTH];
   logic [QW-1:0]      wp_ff;
   logic [QW-1:0]      rp_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               accept;
   logic               enq;
   logic               addr_ok;
   cmd_type            c;

   // Classify the transaction; ignored frames and unknown operations never enter the queue.
   always_comb begin
      addr_ok = (req_data.frame_dst_mac == own_mac) || (req_data.frame_dst_mac == BCAST_MAC);
      c = '0;
      enq = 1'b0;
      c.handle  = req_data.datagram_handle;
      c.elapsed = req_data.elapsed_ms;
      c.mac     = req_data.arp_sender_mac;
      c.reply   = (req_data.arp_opcode == ARP_OP_REQUEST) && (req_data.arp_target_ip == own_ip);
      priority if (req_data.operation == OP_SEND) begin
         c.kind = CMD_SEND;
         c.ip   = req_data.next_hop_ip;
         enq    = 1'b1;
      end else if (req_data.operation == OP_TICK) begin
         c.kind = CMD_TICK;
         enq    = 1'b1;
      end else if (req_data.operation == OP_RECV && addr_ok && req_data.payload_ok) begin
         c.ip = req_data.arp_sender_ip;
         if (req_data.frame_ethertype == ETH_IPV4) begin
            c.kind = CMD_DELIVER;
            enq    = 1'b1;
         end else if (req_data.frame_ethertype == ETH_ARP) begin
            c.kind = CMD_ARP;
            enq    = 1'b1;
         end
      end else begin
         enq = 1'b0;
      end
   end

   assign req_stall = (cnt_ff == CNT_W'(CMD_QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (accept && enq) begin
            q_ff[wp_ff] <= c;
            wp_ff <= (wp_ff == QW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         end
         if (cmd_pop) begin
            rp_ff <= (rp_ff == QW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CNT_W'(accept && enq) - CNT_W'(cmd_pop);
      end
   end

endmodule

// ----- hdl/arp_back.sv -----
`timescale 1ns / 1ps
module arp_back #(
   parameter int CACHE_ENTRIES   = arp_pkg::CACHE_ENTRIES_DEF,
   parameter int REQUEST_ENTRIES = arp_pkg::REQUEST_ENTRIES_DEF,
   parameter int PENDING_ENTRIES = arp_pkg::PENDING_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      cache_lifetime_ms,
   input  logic [15:0]      request_holdoff_ms,
   input  logic             cmd_valid,
   input  arp_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output arp_pkg::rsp_type rsp_data,
   output logic [$clog2(PENDING_ENTRIES+1)-1:0] pend_count
);
   import arp_pkg::*;

   localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int RW = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
   localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
   localparam int PC_W = $clog2(PENDING_ENTRIES + 1);
   localparam int CR_MAX = (CACHE_ENTRIES > REQUEST_ENTRIES) ? CACHE_ENTRIES : REQUEST_ENTRIES;
   localparam int WMAX = (CR_MAX > PENDING_ENTRIES) ? CR_MAX : PENDING_ENTRIES;
   localparam int WK_W = $clog2(WMAX + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DELIV, ST_CWALK, ST_LEARN, ST_RWALK, ST_SREQ,
      ST_SQ, ST_PWALK, ST_REPLY, ST_TICK, ST_FLUSH
   } state_type;

   state_type        st_ff;
   cmd_type          cmd_ff;
   logic [WK_W-1:0]  wk_ff;
   logic [PC_W-1:0]  k_ff;
   logic [PC_W-1:0]  pcnt_ff;
   logic             match_ff, free_ff, held_ff, rfree_ff;
   logic [CW-1:0]    match_slot_ff, free_slot_ff, cmin_ff;
   logic [RW-1:0]    rfree_slot_ff, rmin_ff;

   logic [31:0]      cache_ip_ff   [CACHE_ENTRIES];
   logic [47:0]      cache_mac_ff  [CACHE_ENTRIES];
   logic [15:0]      cache_time_ff [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] cache_valid_ff;
   logic [31:0]      req_ip_ff     [REQUEST_ENTRIES];
   logic [15:0]      req_timer_ff  [REQUEST_ENTRIES];
   logic [15:0]      pend_handle_ff[PENDING_ENTRIES];
   logic [31:0]      pend_ip_ff    [PENDING_ENTRIES];
   logic [15:0]      pend_time_ff  [PENDING_ENTRIES];

   rsp_type          hold_ff;
   logic             hold_vld_ff;
   rsp_type          rsp_ff;
   logic             rsp_vld_ff;

   logic [CW-1:0]    ci;
   logic [RW-1:0]    ri;
   logic [PW-1:0]    pi, ki;
   logic             c_hit, c_end, r_end, t_end, p_done, p_match, p_expire;
   logic             want, can_push, fire, out_free, flush_fire, out_load;
   rsp_type          push_res, out_data;
   logic [CW-1:0]    learn_slot;
   logic [15:0]      rtmr;

   assign ci = wk_ff[CW-1:0];
   assign ri = wk_ff[RW-1:0];
   assign pi = wk_ff[PW-1:0];
   assign ki = k_ff[PW-1:0];
   assign rtmr     = req_timer_ff[ri];
   assign c_hit    = cache_valid_ff[ci] && (cache_ip_ff[ci] == cmd_ff.ip);
   assign c_end    = (wk_ff == WK_W'(CACHE_ENTRIES - 1));
   assign r_end    = (wk_ff == WK_W'(REQUEST_ENTRIES - 1));
   assign t_end    = (wk_ff == WK_W'(CR_MAX - 1));
   assign p_done   = (wk_ff >= WK_W'(pcnt_ff));
   assign p_match  = (pend_ip_ff[pi] == cmd_ff.ip);
   assign p_expire = (pend_time_ff[pi] <= cmd_ff.elapsed);
   assign learn_slot = match_ff ? match_slot_ff : (free_ff ? free_slot_ff : cmin_ff);

   // Result to be produced in this cycle, if any.
   always_comb begin
      want = 1'b0;
      push_res = '0;
      unique case (st_ff)
         ST_DELIV: begin
            want = 1'b1;
            push_res.result_kind = RK_DELIVER;
            push_res.out_handle  = cmd_ff.handle;
         end
         ST_CWALK: begin
            want = (cmd_ff.kind == CMD_SEND) && c_hit;
            push_res.result_kind = RK_FRAME;
            push_res.dest_mac    = cache_mac_ff[ci];
            push_res.out_handle  = cmd_ff.handle;
         end
         ST_SREQ: begin
            want = !held_ff;
            push_res.result_kind       = RK_REQUEST;
            push_res.dest_mac          = BCAST_MAC;
            push_res.request_target_ip = cmd_ff.ip;
         end
         ST_SQ: begin
            want = (pcnt_ff >= PC_W'(PENDING_ENTRIES));
            push_res.result_kind = RK_DROP;
            push_res.out_handle  = cmd_ff.handle;
         end
         ST_PWALK: begin
            want = (cmd_ff.kind == CMD_ARP) && !p_done && p_match;
            push_res.result_kind = RK_FRAME;
            push_res.dest_mac    = cmd_ff.mac;
            push_res.out_handle  = pend_handle_ff[pi];
         end
         ST_REPLY: begin
            want = 1'b1;
            push_res.result_kind       = RK_REPLY;
            push_res.dest_mac          = cmd_ff.mac;
            push_res.request_target_ip = cmd_ff.ip;
         end
         default: want = 1'b0;
      endcase
   end

   // A result waits in the hold register until the next one shows whether it was the last.
   assign out_free   = !rsp_vld_ff || !rsp_stall;
   assign can_push   = !hold_vld_ff || out_free;
   assign fire       = want && can_push;
   assign flush_fire = (st_ff == ST_FLUSH) && hold_vld_ff && out_free;
   assign out_load   = (fire && hold_vld_ff) || flush_fire;
   always_comb begin
      out_data = hold_ff;
      out_data.last = flush_fire;
   end

   assign cmd_pop    = (st_ff == ST_IDLE) && cmd_valid;
   assign rsp_valid  = rsp_vld_ff;
   assign rsp_data   = rsp_ff;
   assign pend_count = pcnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff          <= ST_IDLE;
         hold_vld_ff    <= 1'b0;
         rsp_vld_ff     <= 1'b0;
         cache_valid_ff <= '0;
         pcnt_ff        <= '0;
         for (int i = 0; i < REQUEST_ENTRIES; i++) begin
            req_timer_ff[i] <= '0;
         end
      end else begin
         if (out_load) begin
            rsp_ff     <= out_data;
            rsp_vld_ff <= 1'b1;
         end else if (out_free) begin
            rsp_vld_ff <= 1'b0;
         end
         if (fire) begin
            hold_ff     <= push_res;
            hold_vld_ff <= 1'b1;
         end else if (flush_fire) begin
            hold_vld_ff <= 1'b0;
         end

         unique case (st_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd;
                  wk_ff    <= '0;
                  k_ff     <= '0;
                  match_ff <= 1'b0;
                  free_ff  <= 1'b0;
                  held_ff  <= 1'b0;
                  rfree_ff <= 1'b0;
                  unique case (cmd.kind)
                     CMD_SEND:    st_ff <= ST_CWALK;
                     CMD_DELIVER: st_ff <= ST_DELIV;
                     CMD_ARP:     st_ff <= ST_CWALK;
                     CMD_TICK:    st_ff <= ST_TICK;
                     default:     st_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_DELIV: begin
               if (fire) st_ff <= ST_FLUSH;
            end
            ST_CWALK: begin
               if (cmd_ff.kind == CMD_SEND) begin
                  if (c_hit) begin
                     if (fire) st_ff <= ST_FLUSH;
                  end else if (c_end) begin
                     st_ff <= ST_RWALK;
                     wk_ff <= '0;
                  end else begin
                     wk_ff <= wk_ff + 1'b1;
                  end
               end else begin
                  if (c_hit && !match_ff) begin
                     match_ff      <= 1'b1;
                     match_slot_ff <= ci;
                  end
                  if (!cache_valid_ff[ci] && !free_ff) begin
                     free_ff      <= 1'b1;
                     free_slot_ff <= ci;
                  end
                  if (wk_ff == '0 || cache_time_ff[ci] < cache_time_ff[cmin_ff]) begin
                     cmin_ff <= ci;
                  end
                  if (c_end) st_ff <= ST_LEARN;
                  else wk_ff <= wk_ff + 1'b1;
               end
            end
            ST_LEARN: begin
               cache_valid_ff[learn_slot] <= 1'b1;
               cache_ip_ff[learn_slot]    <= cmd_ff.ip;
               cache_mac_ff[learn_slot]   <= cmd_ff.mac;
               cache_time_ff[learn_slot]  <= cache_lifetime_ms;
               st_ff <= ST_PWALK;
               wk_ff <= '0;
               k_ff  <= '0;
            end
            ST_RWALK: begin
               if (rtmr != '0 && req_ip_ff[ri] == cmd_ff.ip) held_ff <= 1'b1;
               if (rtmr == '0 && !rfree_ff) begin
                  rfree_ff      <= 1'b1;
                  rfree_slot_ff <= ri;
               end
               if (wk_ff == '0 || rtmr < req_timer_ff[rmin_ff]) rmin_ff <= ri;
               if (r_end) st_ff <= ST_SREQ;
               else wk_ff <= wk_ff + 1'b1;
            end
            ST_SREQ: begin
               if (held_ff) begin
                  st_ff <= ST_SQ;
               end else if (fire) begin
                  req_ip_ff[rfree_ff ? rfree_slot_ff : rmin_ff]    <= cmd_ff.ip;
                  req_timer_ff[rfree_ff ? rfree_slot_ff : rmin_ff] <= request_holdoff_ms;
                  st_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               if (pcnt_ff < PC_W'(PENDING_ENTRIES)) begin
                  pend_handle_ff[pcnt_ff[PW-1:0]] <= cmd_ff.handle;
                  pend_ip_ff[pcnt_ff[PW-1:0]]     <= cmd_ff.ip;
                  pend_time_ff[pcnt_ff[PW-1:0]]   <= request_holdoff_ms;
                  pcnt_ff <= pcnt_ff + 1'b1;
                  st_ff   <= ST_FLUSH;
               end else if (fire) begin
                  st_ff <= ST_FLUSH;
               end
            end
            ST_PWALK: begin
               if (p_done) begin
                  pcnt_ff <= k_ff;
                  st_ff   <= (cmd_ff.kind == CMD_ARP && cmd_ff.reply) ? ST_REPLY : ST_FLUSH;
               end else if (cmd_ff.kind == CMD_ARP) begin
                  if (p_match) begin
                     if (fire) wk_ff <= wk_ff + 1'b1;
                  end else begin
                     pend_handle_ff[ki] <= pend_handle_ff[pi];
                     pend_ip_ff[ki]     <= pend_ip_ff[pi];
                     pend_time_ff[ki]   <= pend_time_ff[pi];
                     k_ff  <= k_ff + 1'b1;
                     wk_ff <= wk_ff + 1'b1;
                  end
               end else begin
                  if (!p_expire) begin
                     pend_handle_ff[ki] <= pend_handle_ff[pi];
                     pend_ip_ff[ki]     <= pend_ip_ff[pi];
                     pend_time_ff[ki]   <= pend_time_ff[pi] - cmd_ff.elapsed;
                     k_ff <= k_ff + 1'b1;
                  end
                  wk_ff <= wk_ff + 1'b1;
               end
            end
            ST_REPLY: begin
               if (fire) st_ff <= ST_FLUSH;
            end
            ST_TICK: begin
               if (wk_ff < WK_W'(CACHE_ENTRIES) && cache_valid_ff[ci]) begin
                  if (cache_time_ff[ci] <= cmd_ff.elapsed) cache_valid_ff[ci] <= 1'b0;
                  else cache_time_ff[ci] <= cache_time_ff[ci] - cmd_ff.elapsed;
               end
               if (wk_ff < WK_W'(REQUEST_ENTRIES)) begin
                  req_timer_ff[ri] <= (rtmr <= cmd_ff.elapsed) ? '0 : rtmr - cmd_ff.elapsed;
               end
               if (t_end) begin
                  st_ff <= ST_PWALK;
                  wk_ff <= '0;
                  k_ff  <= '0;
               end else begin
                  wk_ff <= wk_ff + 1'b1;
               end
            end
            ST_FLUSH: begin
               if (!hold_vld_ff || flush_fire) st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
